// ===== sv/bda_pkg.sv =====
// Shared types and constants for the button debounce and auto-repeat block.
`timescale 1ns / 1ps
`default_nettype none

package bda_pkg;

    localparam int NUM_SLOTS = 7;
    localparam int CODE_W    = 3;
    localparam int TIME_W    = 32;
    localparam int CFG_W     = 16;
    localparam int IDX_W     = 3;

    localparam int KEY_PLAY  = 0;
    localparam int KEY_STOP  = 1;
    localparam int KEY_LEFT  = 2;
    localparam int KEY_RIGHT = 3;
    localparam int KEY_MODE  = 4;
    localparam int KEY_OK    = 5;
    localparam int KEY_PANIC = 6;

    localparam logic [CODE_W-1:0] CODE_NONE  = 3'd0;
    localparam logic [CODE_W-1:0] CODE_PLAY  = 3'd1;
    localparam logic [CODE_W-1:0] CODE_STOP  = 3'd2;
    localparam logic [CODE_W-1:0] CODE_LEFT  = 3'd3;
    localparam logic [CODE_W-1:0] CODE_RIGHT = 3'd4;
    localparam logic [CODE_W-1:0] CODE_MODE  = 3'd5;
    localparam logic [CODE_W-1:0] CODE_OK    = 3'd6;
    localparam logic [CODE_W-1:0] CODE_PANIC = 3'd7;

    typedef enum logic [IDX_W-1:0] {
        CFG_DEBOUNCE      = 3'd0,
        CFG_HOLD_THRESH   = 3'd1,
        CFG_ACCEL_FIRST   = 3'd2,
        CFG_ACCEL_SECOND  = 3'd3,
        CFG_DELAY_INITIAL = 3'd4,
        CFG_DELAY_FAST    = 3'd5,
        CFG_DELAY_FASTEST = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        logic [CFG_W-1:0] debounce_ms;
        logic [CFG_W-1:0] hold_threshold_ms;
        logic [CFG_W-1:0] accel_first_ms;
        logic [CFG_W-1:0] accel_second_ms;
        logic [CFG_W-1:0] delay_initial_ms;
        logic [CFG_W-1:0] delay_fast_ms;
        logic [CFG_W-1:0] delay_fastest_ms;
    } cfg_t;

    typedef struct packed {
        logic                 press;
        logic [CODE_W-1:0]    code;
        logic [NUM_SLOTS-1:0] down;
    } scan_t;

endpackage

`default_nettype wire

// ===== sv/bda_cell.sv =====
// One button cell: level history, last press time and the scan token hand-off.
`timescale 1ns / 1ps
`default_nettype none

module bda_cell
    import bda_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              step,
    input  wire logic              level,
    input  wire logic [TIME_W-1:0] now_ms,
    input  wire logic [CFG_W-1:0]  debounce_ms,
    input  wire logic              claim_in,
    output logic                   claim_out,
    output logic                   press
);

    logic              prev_reg;
    logic              prev_next;
    logic [TIME_W-1:0] time_reg;
    logic [TIME_W-1:0] time_next;
    logic [TIME_W-1:0] age;

    always_comb
    begin
        age       = now_ms - time_reg;
        press     = !level && prev_reg && !claim_in &&
                    (age >= {{(TIME_W-CFG_W){1'b0}}, debounce_ms});
        claim_out = claim_in || press;
        prev_next = prev_reg;
        time_next = time_reg;
        if (step && !claim_in)
        begin
            prev_next = level;
        end
        if (step && press)
        begin
            time_next = now_ms;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg <= 1'b1;
            time_reg <= '0;
        end
        else
        begin
            prev_reg <= prev_next;
            time_reg <= time_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/bda_repeat.sv =====
// Held-button latch and accelerating auto-repeat for left and right.
`timescale 1ns / 1ps
`default_nettype none

module bda_repeat
    import bda_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              step,
    input  wire logic [TIME_W-1:0] now_ms,
    input  wire scan_t             scan,
    input  wire cfg_t              cfg,
    output logic [CODE_W-1:0]      event_button
);

    logic [CODE_W-1:0] held_reg;
    logic [CODE_W-1:0] held_next;
    logic [TIME_W-1:0] start_reg;
    logic [TIME_W-1:0] start_next;
    logic [TIME_W-1:0] rpt_reg;
    logic [TIME_W-1:0] rpt_next;
    logic [CODE_W-1:0] held;
    logic [TIME_W-1:0] dur;
    logic [TIME_W-1:0] since;
    logic [CFG_W-1:0]  delay;

    always_comb
    begin
        priority if (scan.down[KEY_LEFT])  held = CODE_LEFT;
        else if (scan.down[KEY_RIGHT])     held = CODE_RIGHT;
        else if (scan.down[KEY_PLAY])      held = CODE_PLAY;
        else if (scan.down[KEY_STOP])      held = CODE_STOP;
        else if (scan.down[KEY_MODE])      held = CODE_MODE;
        else if (scan.down[KEY_OK])        held = CODE_OK;
        else if (scan.down[KEY_PANIC])     held = CODE_PANIC;
        else                               held = CODE_NONE;
    end

    always_comb
    begin
        dur   = now_ms - start_reg;
        since = now_ms - rpt_reg;
        priority if (dur > {{(TIME_W-CFG_W){1'b0}}, cfg.accel_second_ms})
            delay = cfg.delay_fastest_ms;
        else if (dur > {{(TIME_W-CFG_W){1'b0}}, cfg.accel_first_ms})
            delay = cfg.delay_fast_ms;
        else
            delay = cfg.delay_initial_ms;
    end

    always_comb
    begin
        event_button = CODE_NONE;
        held_next    = held_reg;
        start_next   = start_reg;
        rpt_next     = rpt_reg;
        if (scan.press)
        begin
            event_button = scan.code;
            held_next    = scan.code;
            start_next   = now_ms;
            rpt_next     = now_ms;
        end
        else if (held == CODE_NONE || held != held_reg)
        begin
            held_next = CODE_NONE;
        end
        else if ((held == CODE_LEFT || held == CODE_RIGHT) &&
                 dur >= {{(TIME_W-CFG_W){1'b0}}, cfg.hold_threshold_ms} &&
                 since >= {{(TIME_W-CFG_W){1'b0}}, delay})
        begin
            event_button = held;
            rpt_next     = now_ms;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg  <= CODE_NONE;
            start_reg <= '0;
            rpt_reg   <= '0;
        end
        else if (step)
        begin
            held_reg  <= held_next;
            start_reg <= start_next;
            rpt_reg   <= rpt_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/button_debounce_autorepeat_top.sv =====
// Top level: button cell chain, repeat logic, config registers, output buffer.
//
//  channel  | dir | handshake           | payload
//  ---------+-----+---------------------+-------------------------------------
//  s_*      | in  | s_tvalid / s_tready | s_tdata: levels[6:0], now_ms[38:7]
//  m_*      | out | m_tvalid / m_tready | m_tdata: event_button[2:0]
//  cfg_*    | in  | cfg_valid/cfg_ready | cfg_index[2:0], cfg_data[15:0]
//
// One sample per cycle while s_tready is high; each accepted sample yields one registered output word.
// The critical path is the press-token ripple across the cells plus one 32-bit compare.
// A two-word output buffer keeps s_tready high while one word waits on m_tready.
// Reset restores all buttons as released, all times to zero and default config.
// cfg_ready is always high.
`timescale 1ns / 1ps
`default_nettype none

module button_debounce_autorepeat_top
    import bda_pkg::*;
#(
    parameter int NUM_BUTTONS = 7
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [39:0]      s_tdata,   // levels[6:0], now_ms[38:7], zero pad
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic [7:0]            m_tdata,   // event_button[2:0], zero pad
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0] cfg_data
);

    localparam int NUM_ACTIVE = (NUM_BUTTONS < NUM_SLOTS) ? NUM_BUTTONS : NUM_SLOTS;

    logic [NUM_SLOTS-1:0] levels;
    logic [TIME_W-1:0]    now_ms;
    logic                 step;
    logic                 pop;
    logic [NUM_ACTIVE:0]  claim;
    logic [NUM_SLOTS-1:0] press;
    logic [NUM_SLOTS-1:0] down;
    scan_t                scan;
    cfg_t                 cfg_reg;
    logic [CODE_W-1:0]    event_button;
    logic [CODE_W-1:0]    head_reg;
    logic [CODE_W-1:0]    head_next;
    logic [CODE_W-1:0]    tail_reg;
    logic [CODE_W-1:0]    tail_next;
    logic [1:0]           cnt_reg;
    logic [1:0]           cnt_next;

    assign levels    = s_tdata[NUM_SLOTS-1:0];
    assign now_ms    = s_tdata[NUM_SLOTS+TIME_W-1:NUM_SLOTS];
    assign s_tready  = (cnt_reg != 2'd2);
    assign m_tvalid  = (cnt_reg != 2'd0);
    assign m_tdata   = {5'd0, head_reg};
    assign cfg_ready = 1'b1;
    assign step      = s_tvalid && s_tready;
    assign pop       = m_tvalid && m_tready;
    assign claim[0]  = 1'b0;

    genvar g;
    generate
        for (g = 0; g < NUM_SLOTS; g++)
        begin : g_slot
            if (g < NUM_ACTIVE)
            begin : g_cell
                bda_cell u_cell (
                    .clk         (clk),
                    .rst_n       (rst_n),
                    .step        (step),
                    .level       (levels[g]),
                    .now_ms      (now_ms),
                    .debounce_ms (cfg_reg.debounce_ms),
                    .claim_in    (claim[g]),
                    .claim_out   (claim[g+1]),
                    .press       (press[g])
                );
                assign down[g] = !levels[g];
            end
            else
            begin : g_none
                assign press[g] = 1'b0;
                assign down[g]  = 1'b0;
            end
        end
    endgenerate

    always_comb
    begin
        scan.press = claim[NUM_ACTIVE];
        scan.down  = down;
        scan.code  = CODE_NONE;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            if (press[i])
            begin
                scan.code = scan.code | CODE_W'(i + 1);
            end
        end
    end

    bda_repeat u_repeat (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .now_ms       (now_ms),
        .scan         (scan),
        .cfg          (cfg_reg),
        .event_button (event_button)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ms       <= 16'd50;
            cfg_reg.hold_threshold_ms <= 16'd500;
            cfg_reg.accel_first_ms    <= 16'd1000;
            cfg_reg.accel_second_ms   <= 16'd2000;
            cfg_reg.delay_initial_ms  <= 16'd200;
            cfg_reg.delay_fast_ms     <= 16'd100;
            cfg_reg.delay_fastest_ms  <= 16'd50;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_DEBOUNCE:      cfg_reg.debounce_ms       <= cfg_data;
                CFG_HOLD_THRESH:   cfg_reg.hold_threshold_ms <= cfg_data;
                CFG_ACCEL_FIRST:   cfg_reg.accel_first_ms    <= cfg_data;
                CFG_ACCEL_SECOND:  cfg_reg.accel_second_ms   <= cfg_data;
                CFG_DELAY_INITIAL: cfg_reg.delay_initial_ms  <= cfg_data;
                CFG_DELAY_FAST:    cfg_reg.delay_fast_ms     <= cfg_data;
                CFG_DELAY_FASTEST: cfg_reg.delay_fastest_ms  <= cfg_data;
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        cnt_next  = cnt_reg;
        unique case ({step, pop})
            2'b10:
            begin
                if (cnt_reg == 2'd0)
                    head_next = event_button;
                else
                    tail_next = event_button;
                cnt_next = cnt_reg + 2'd1;
            end
            2'b01:
            begin
                head_next = tail_reg;
                cnt_next  = cnt_reg - 2'd1;
            end
            2'b11:
            begin
                if (cnt_reg == 2'd1)
                begin
                    head_next = event_button;
                end
                else
                begin
                    head_next = tail_reg;
                    tail_next = event_button;
                end
            end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

endmodule

`default_nettype wire

// ===== sv/bda_checker.sv =====
// Port-level checks for the debounce block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module bda_checker
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       s_tvalid,
    input wire logic       s_tready,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output word dropped or changed while stalled");

    a_out_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[7:3] == 5'd0)
        else $error("output pad bits not zero");

    a_full_valid: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no output word pending");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && !m_tvalid |=> m_tvalid)
        else $error("accepted sample gave no output word next cycle");

endmodule

bind button_debounce_autorepeat_top bda_checker u_bda_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the debounced keypad with accelerating auto-repeat.
`timescale 1ns / 1ps

import bda_pkg::*;

class keypad_scoreboard;
    cfg_t              regs;
    logic              prev_level [NUM_SLOTS];
    logic [TIME_W-1:0] press_time [NUM_SLOTS];
    logic [CODE_W-1:0] held_code;
    logic [TIME_W-1:0] hold_start;
    logic [TIME_W-1:0] repeat_time;
    logic [CODE_W-1:0] event_queue [$];
    int                errors;
    int                samples;
    int                presses;
    int                repeats;
    int                writes;

    function new();
        regs.debounce_ms       = 16'd50;
        regs.hold_threshold_ms = 16'd500;
        regs.accel_first_ms    = 16'd1000;
        regs.accel_second_ms   = 16'd2000;
        regs.delay_initial_ms  = 16'd200;
        regs.delay_fast_ms     = 16'd100;
        regs.delay_fastest_ms  = 16'd50;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            prev_level[i] = 1'b1;
            press_time[i] = '0;
        end
        held_code   = CODE_NONE;
        hold_start  = '0;
        repeat_time = '0;
        errors      = 0;
        samples     = 0;
        presses     = 0;
        repeats     = 0;
        writes      = 0;
    endfunction

    function void write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        writes++;
        case (idx)
            CFG_DEBOUNCE:      regs.debounce_ms       = data;
            CFG_HOLD_THRESH:   regs.hold_threshold_ms = data;
            CFG_ACCEL_FIRST:   regs.accel_first_ms    = data;
            CFG_ACCEL_SECOND:  regs.accel_second_ms   = data;
            CFG_DELAY_INITIAL: regs.delay_initial_ms  = data;
            CFG_DELAY_FAST:    regs.delay_fast_ms     = data;
            CFG_DELAY_FASTEST: regs.delay_fastest_ms  = data;
            default: ;
        endcase
    endfunction

    function void note_sample(logic [NUM_SLOTS-1:0] levels, logic [TIME_W-1:0] now_ms);
        int                hold_order [NUM_SLOTS];
        logic [CODE_W-1:0] code;
        logic [CODE_W-1:0] held;
        logic [TIME_W-1:0] elapsed;
        logic [TIME_W-1:0] dur;
        logic [TIME_W-1:0] interval;
        bit                pressed;
        hold_order = '{KEY_LEFT, KEY_RIGHT, KEY_PLAY, KEY_STOP, KEY_MODE, KEY_OK, KEY_PANIC};
        code    = CODE_NONE;
        pressed = 1'b0;
        samples++;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            if (!pressed)
            begin
                elapsed = now_ms - press_time[i];
                if (!levels[i] && prev_level[i] && elapsed >= regs.debounce_ms)
                begin
                    press_time[i] = now_ms;
                    prev_level[i] = 1'b0;
                    held_code     = CODE_W'(i + 1);
                    hold_start    = now_ms;
                    repeat_time   = now_ms;
                    code          = held_code;
                    pressed       = 1'b1;
                    presses++;
                end
                else
                    prev_level[i] = levels[i];
            end
        end
        if (!pressed)
        begin
            held = CODE_NONE;
            for (int k = 0; k < NUM_SLOTS; k++)
                if (held == CODE_NONE && !levels[hold_order[k]])
                    held = CODE_W'(hold_order[k] + 1);
            if (held == CODE_NONE || held != held_code)
                held_code = CODE_NONE;
            else if (held == CODE_LEFT || held == CODE_RIGHT)
            begin
                dur = now_ms - hold_start;
                if (dur >= regs.hold_threshold_ms)
                begin
                    if (dur > regs.accel_second_ms)
                        interval = regs.delay_fastest_ms;
                    else if (dur > regs.accel_first_ms)
                        interval = regs.delay_fast_ms;
                    else
                        interval = regs.delay_initial_ms;
                    elapsed = now_ms - repeat_time;
                    if (elapsed >= interval)
                    begin
                        repeat_time = now_ms;
                        code        = held;
                        repeats++;
                    end
                end
            end
        end
        event_queue.push_back(code);
    endfunction

    function void check_event(logic [7:0] word);
        logic [CODE_W-1:0] want;
        if (event_queue.size() == 0)
        begin
            $error("unexpected output word %0h", word);
            errors++;
        end
        else
        begin
            want = event_queue.pop_front();
            if (word[CODE_W-1:0] !== want)
            begin
                $error("event_button: expected %0d, got %0d", want, word[CODE_W-1:0]);
                errors++;
            end
        end
    endfunction
endclass

module testbench;

    localparam int                 NUM_REGS      = 7;
    localparam int                 CYCLE_LIMIT   = 600000;
    localparam int                 CHOKE_CYCLES  = 200;
    localparam logic [IDX_W-1:0]   CFG_IDX_SPARE = 3'd7;
    localparam logic [NUM_SLOTS-1:0] ALL_UP      = 7'h7F;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             s_tvalid  = 1'b0;
    logic             s_tready;
    logic [39:0]      s_tdata   = '0;
    logic             m_tvalid;
    logic             m_tready  = 1'b0;
    logic [7:0]       m_tdata;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data  = '0;

    keypad_scoreboard  sb = new();
    logic [TIME_W-1:0] clock_ms    = 32'd100;
    bit                quiet       = 1'b0;
    bit                choke_req   = 1'b0;
    bit                choke_done  = 1'b0;
    int                cycle_count = 0;

    button_debounce_autorepeat_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    task automatic push_sample(input logic [NUM_SLOTS-1:0] levels, input logic [TIME_W-1:0] now_ms);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, now_ms, levels};
        do @(posedge clk); while (!s_tready);
        sb.note_sample(levels, now_ms);
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic write_word(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        sb.write_reg(idx, data);
    endtask

    task automatic program_regs(input cfg_t c, input bit poke_spare);
        logic [CFG_W-1:0] vals [NUM_REGS];
        vals = '{c.debounce_ms, c.hold_threshold_ms, c.accel_first_ms, c.accel_second_ms,
                 c.delay_initial_ms, c.delay_fast_ms, c.delay_fastest_ms};
        for (int i = 0; i < NUM_REGS; i++)
            write_word(IDX_W'(i), vals[i]);
        if (poke_spare)
            write_word(CFG_IDX_SPARE, 16'hFFFF);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.event_queue.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic step_time(input int scale);
        int r;
        r = $urandom_range(0, 99);
        if (r < 94)
            clock_ms += $urandom_range(0, scale);
        else if (r < 98)
            clock_ms += $urandom_range(0, 200000);
        else
            clock_ms = $urandom;
    endtask

    task automatic burst(input int scale, inout int budget);
        int                   btn;
        int                   n;
        logic [NUM_SLOTS-1:0] levels;
        quiet = ($urandom_range(0, 4) == 0);
        if ($urandom_range(0, 99) < 75)
        begin
            if ($urandom_range(0, 1))
                btn = $urandom_range(0, 1) ? KEY_LEFT : KEY_RIGHT;
            else
                btn = $urandom_range(0, NUM_SLOTS - 1);
            n = $urandom_range(1, 24);
            for (int k = 0; k < n && budget > 0; k++)
            begin
                levels      = ALL_UP;
                levels[btn] = 1'b0;
                if ($urandom_range(0, 9) == 0)
                    levels &= NUM_SLOTS'($urandom);
                step_time(scale);
                push_sample(levels, clock_ms);
                budget--;
            end
            n = $urandom_range(1, 3);
            for (int k = 0; k < n && budget > 0; k++)
            begin
                levels = ($urandom_range(0, 7) == 0) ? NUM_SLOTS'($urandom) : ALL_UP;
                step_time(scale);
                push_sample(levels, clock_ms);
                budget--;
            end
        end
        else
        begin
            step_time(scale);
            push_sample(NUM_SLOTS'($urandom_range(0, 127)), clock_ms);
            budget--;
        end
    endtask

    task automatic run_phase(input cfg_t c, input bit poke_spare, input int scale,
                             input int count, input bit squeeze);
        int budget;
        budget = count;
        drain();
        program_regs(c, poke_spare);
        if (squeeze)
            choke_req = 1'b1;
        while (budget > 0)
            burst(scale, budget);
        quiet = 1'b0;
    endtask

    // Receiver: random stalls plus one long hold-off on request.
    initial
    begin
        int hold_left;
        hold_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                sb.check_event(m_tdata);
            if (choke_req && !choke_done)
            begin
                hold_left  = CHOKE_CYCLES;
                choke_done = 1'b1;
            end
            else if (hold_left == 0)
                hold_left = pick_gap();
            else
                hold_left--;
            m_tready <= (hold_left == 0);
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("testbench failed");
        $finish;
    end

    initial
    begin
        cfg_t base_cfg;
        cfg_t tight_cfg;
        cfg_t zero_cfg;
        cfg_t full_cfg;
        cfg_t rand_cfg;
        base_cfg  = '{16'd50, 16'd500, 16'd1000, 16'd2000, 16'd200, 16'd100, 16'd50};
        tight_cfg = '{16'd5, 16'd20, 16'd40, 16'd80, 16'd10, 16'd5, 16'd2};
        zero_cfg  = '0;
        full_cfg  = '1;
        rand_cfg  = '{CFG_W'($urandom_range(0, 3000)), CFG_W'($urandom_range(0, 3000)),
                      CFG_W'($urandom_range(0, 3000)), CFG_W'($urandom_range(0, 3000)),
                      CFG_W'($urandom_range(0, 3000)), CFG_W'($urandom_range(0, 3000)),
                      CFG_W'($urandom_range(0, 3000))};

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes, stale levels after a press, debounce, each button, repeat steps.
        push_sample(ALL_UP, 32'd100);
        push_sample('0, 32'd200);
        push_sample('0, 32'd210);
        push_sample(ALL_UP, 32'd220);
        push_sample(7'h7E, 32'd230);
        clock_ms = 32'd300;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            clock_ms += 100;
            push_sample(ALL_UP & ~(7'd1 << i), clock_ms);
            clock_ms += 100;
            push_sample(ALL_UP, clock_ms);
        end
        clock_ms = 32'd10000;
        push_sample(ALL_UP & ~(7'd1 << KEY_LEFT), clock_ms);
        push_sample(ALL_UP & ~(7'd1 << KEY_LEFT), clock_ms + 499);
        push_sample(ALL_UP & ~(7'd1 << KEY_LEFT), clock_ms + 500);
        push_sample(ALL_UP & ~(7'd1 << KEY_LEFT), clock_ms + 1000);
        push_sample(ALL_UP & ~(7'd1 << KEY_LEFT), clock_ms + 1001);
        push_sample(ALL_UP & ~(7'd1 << KEY_LEFT), clock_ms + 2100);
        push_sample(ALL_UP & ~(7'd1 << KEY_LEFT), clock_ms + 2150);
        clock_ms += 3000;

        run_phase(base_cfg, 1'b1, 250, 150, 1'b0);
        run_phase(tight_cfg, 1'b0, 12, 150, 1'b0);
        run_phase(zero_cfg, 1'b0, 3, 100, 1'b0);
        clock_ms = 32'hFFFF_0000;
        run_phase(full_cfg, 1'b0, 12000, 100, 1'b0);
        run_phase(rand_cfg, 1'b1, 300, 100, 1'b1);
        clock_ms = 32'hFFFF_F000;
        run_phase(base_cfg, 1'b0, 250, 100, 1'b0);
        drain();

        $display("Covered %0d samples over six register phases, with time wrap and a long output stall.",
                 sb.samples);
        $display("Saw %0d accepted presses and %0d auto-repeats after %0d register writes.",
                 sb.presses, sb.repeats, sb.writes);
        if (sb.errors == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
